@@ design/wsd_pkg.sv @@
// Shared types and constants for the WebSocket frame deframer.
package wsd_pkg;

    localparam int LEN_W = 63;

    localparam logic [1:0] HDR1_RSV_MASK = 2'b11;
    localparam logic [6:0] LEN7_MAX      = 7'd125;
    localparam logic [6:0] LEN7_EXT16    = 7'd126;
    localparam logic [2:0] LEN64_LAST    = 3'd7;
    localparam logic [2:0] KEY_LAST      = 3'd3;

    typedef enum logic [2:0] {
        PH_HDR1  = 3'd0,
        PH_HDR2  = 3'd1,
        PH_LEN16 = 3'd2,
        PH_LEN64 = 3'd3,
        PH_MASK  = 3'd4,
        PH_DATA  = 3'd5,
        PH_ERROR = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_RSV         = 3'd1,
        ST_LEN16_SHORT = 3'd2,
        ST_LEN64_TOP   = 3'd3,
        ST_LEN64_SHORT = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0]       payload_byte;
        logic             byte_valid;
        logic             frame_end;
        logic             fin_flag;
        logic             rsv1_flag;
        logic [3:0]       frame_opcode;
        logic [LEN_W-1:0] frame_length;
        t_status          status;
    } t_result;

endpackage

@@ design/websocket_frame_deframer.sv @@
// WebSocket frame deframer: one stream byte per unstalled cycle in, unmasked payload out.
// Each result is registered in the output register, via the skid stage if output stalls.
// Throughput: one byte per cycle unless stalled; parser state updates on acceptance.
// An output register plus a one-entry skid stage let input continue while a result waits.
// Reset (i_rst_n low, synchronous) returns the parser to the first header byte and
// empties the output stages; a clear command does the same to the parser state.
module websocket_frame_deframer (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_command,
    input  logic [7:0]                i_in_byte,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [7:0]                o_payload_byte,
    output logic                      o_byte_valid,
    output logic                      o_frame_end,
    output logic                      o_fin_flag,
    output logic                      o_rsv1_flag,
    output logic [3:0]                o_frame_opcode,
    output logic [wsd_pkg::LEN_W-1:0] o_frame_length,
    output logic [2:0]                o_status
);
    import wsd_pkg::*;

    logic    accept;
    logic    res_valid;
    t_result res;
    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;
    logic    out_free;

    assign o_in_stall = r_skid_valid;
    assign accept     = i_in_valid && !r_skid_valid;
    assign out_free   = !r_out_valid || !i_out_stall;

    wsd_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_command   (i_command),
        .i_in_byte   (i_in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= accept && res_valid;
            end
        end else if (accept && res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : res;
        end else if (accept && res_valid) begin
            r_skid <= res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_payload_byte = r_out.payload_byte;
    assign o_byte_valid   = r_out.byte_valid;
    assign o_frame_end    = r_out.frame_end;
    assign o_fin_flag     = r_out.fin_flag;
    assign o_rsv1_flag    = r_out.rsv1_flag;
    assign o_frame_opcode = r_out.frame_opcode;
    assign o_frame_length = r_out.frame_length;
    assign o_status       = r_out.status;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage holds a transaction while output is empty");

    a_data_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.byte_valid || r_out.frame_end)) |-> (r_out.status == ST_OK))
        else $error("payload or frame end carries an error status");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_out_stall) |=> !r_skid_valid)
        else $error("skid stage did not drain");

endmodule

@@ design/wsd_parse.sv @@
// Frame header parser and payload unmasking for one stream byte per transaction.
module wsd_parse (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic             i_command,
    input  logic [7:0]       i_in_byte,
    output logic             o_res_valid,
    output wsd_pkg::t_result o_res
);
    import wsd_pkg::*;

    t_phase           r_phase, n_phase;
    logic             r_fin, n_fin;
    logic             r_rsv1, n_rsv1;
    logic [3:0]       r_opcode, n_opcode;
    logic             r_masked, n_masked;
    logic [LEN_W-1:0] r_len, n_len;
    logic [LEN_W-1:0] r_rcount, n_rcount;
    logic [31:0]      r_key, n_key;
    logic [2:0]       r_hbc, n_hbc;

    logic [6:0]       len7;
    logic             hdr1_err;
    logic [15:0]      len16;
    logic             len16_short;
    logic [63:0]      len64;
    logic             len64_short;
    logic [LEN_W-1:0] rcount_inc;
    logic             data_end;
    logic [7:0]       key_byte;

    assign len7        = i_in_byte[6:0];
    assign hdr1_err    = (i_in_byte[5:4] & HDR1_RSV_MASK) != 2'b00;
    assign len16       = {r_len[7:0], i_in_byte};
    assign len16_short = len16 <= {9'd0, LEN7_MAX};
    assign len64       = {r_len[55:0], i_in_byte};
    assign len64_short = len64[62:16] == '0;
    assign rcount_inc  = r_rcount + {{(LEN_W-1){1'b0}}, 1'b1};
    assign data_end    = rcount_inc >= r_len;

    always_comb begin
        case (r_rcount[1:0])
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
    end

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (i_command) begin
            n_phase = PH_HDR1;
        end else begin
            unique case (r_phase)
                PH_HDR1: begin
                    n_phase = hdr1_err ? PH_ERROR : PH_HDR2;
                end
                PH_HDR2: begin
                    if (len7 <= LEN7_MAX) begin
                        if (i_in_byte[7])        n_phase = PH_MASK;
                        else if (len7 == 7'd0)   n_phase = PH_HDR1;
                        else                     n_phase = PH_DATA;
                    end else if (len7 == LEN7_EXT16) begin
                        n_phase = PH_LEN16;
                    end else begin
                        n_phase = PH_LEN64;
                    end
                end
                PH_LEN16: begin
                    if (r_hbc != 3'd0) begin
                        if (len16_short)   n_phase = PH_ERROR;
                        else if (r_masked) n_phase = PH_MASK;
                        else               n_phase = PH_DATA;
                    end
                end
                PH_LEN64: begin
                    if (r_hbc == LEN64_LAST) begin
                        if (len64[63] || len64_short) n_phase = PH_ERROR;
                        else if (r_masked)            n_phase = PH_MASK;
                        else                          n_phase = PH_DATA;
                    end
                end
                PH_MASK: begin
                    if (r_hbc >= KEY_LAST) begin
                        n_phase = (r_len == '0) ? PH_HDR1 : PH_DATA;
                    end
                end
                PH_DATA: begin
                    if (data_end) n_phase = PH_HDR1;
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    // Header fields, counters and result
    always_comb begin
        t_status st;
        logic    data_v;
        logic    end_v;
        logic [7:0] data;
        n_fin       = r_fin;
        n_rsv1      = r_rsv1;
        n_opcode    = r_opcode;
        n_masked    = r_masked;
        n_len       = r_len;
        n_rcount    = r_rcount;
        n_key       = r_key;
        n_hbc       = r_hbc;
        o_res_valid = 1'b0;
        st          = ST_OK;
        data_v      = 1'b0;
        end_v       = 1'b0;
        data        = 8'd0;
        if (i_command) begin
            n_fin    = 1'b0;
            n_rsv1   = 1'b0;
            n_opcode = 4'd0;
            n_masked = 1'b0;
            n_len    = '0;
            n_rcount = '0;
            n_key    = 32'd0;
            n_hbc    = 3'd0;
        end else begin
            unique case (r_phase)
                PH_HDR1: begin
                    n_fin    = i_in_byte[7];
                    n_rsv1   = i_in_byte[6];
                    n_opcode = i_in_byte[3:0];
                    if (hdr1_err) begin
                        o_res_valid = 1'b1;
                        st          = ST_RSV;
                    end
                end
                PH_HDR2: begin
                    n_masked = i_in_byte[7];
                    n_hbc    = 3'd0;
                    if (len7 <= LEN7_MAX) begin
                        n_len    = {{(LEN_W-7){1'b0}}, len7};
                        n_rcount = '0;
                        if (!i_in_byte[7] && len7 == 7'd0) begin
                            o_res_valid = 1'b1;
                            end_v       = 1'b1;
                        end
                    end else begin
                        n_len = '0;
                    end
                end
                PH_LEN16: begin
                    n_len = {{(LEN_W-16){1'b0}}, len16};
                    if (r_hbc == 3'd0) begin
                        n_hbc = 3'd1;
                    end else if (len16_short) begin
                        o_res_valid = 1'b1;
                        st          = ST_LEN16_SHORT;
                    end else begin
                        n_hbc    = 3'd0;
                        n_rcount = '0;
                    end
                end
                PH_LEN64: begin
                    n_len = len64[LEN_W-1:0];
                    if (r_hbc != LEN64_LAST) begin
                        n_hbc = r_hbc + 3'd1;
                    end else if (len64[63]) begin
                        o_res_valid = 1'b1;
                        st          = ST_LEN64_TOP;
                    end else if (len64_short) begin
                        o_res_valid = 1'b1;
                        st          = ST_LEN64_SHORT;
                    end else begin
                        n_hbc    = 3'd0;
                        n_rcount = '0;
                    end
                end
                PH_MASK: begin
                    n_key = {r_key[23:0], i_in_byte};
                    if (r_hbc < KEY_LAST) begin
                        n_hbc = r_hbc + 3'd1;
                    end else begin
                        n_hbc    = 3'd0;
                        n_rcount = '0;
                        if (r_len == '0) begin
                            o_res_valid = 1'b1;
                            end_v       = 1'b1;
                        end
                    end
                end
                PH_DATA: begin
                    o_res_valid = 1'b1;
                    data_v      = 1'b1;
                    end_v       = data_end;
                    data        = r_masked ? (i_in_byte ^ key_byte) : i_in_byte;
                    if (data_end) begin
                        n_rcount = '0;
                        n_hbc    = 3'd0;
                    end else begin
                        n_rcount = rcount_inc;
                    end
                end
                default: begin
                    o_res_valid = 1'b0;
                end
            endcase
        end
        o_res.payload_byte = data;
        o_res.byte_valid   = data_v;
        o_res.frame_end    = end_v;
        o_res.fin_flag     = n_fin;
        o_res.rsv1_flag    = n_rsv1;
        o_res.frame_opcode = n_opcode;
        o_res.frame_length = n_len;
        o_res.status       = st;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR1;
            r_fin    <= 1'b0;
            r_rsv1   <= 1'b0;
            r_opcode <= 4'd0;
            r_masked <= 1'b0;
            r_len    <= '0;
            r_rcount <= '0;
            r_key    <= 32'd0;
            r_hbc    <= 3'd0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_fin    <= n_fin;
            r_rsv1   <= n_rsv1;
            r_opcode <= n_opcode;
            r_masked <= n_masked;
            r_len    <= n_len;
            r_rcount <= n_rcount;
            r_key    <= n_key;
            r_hbc    <= n_hbc;
        end
    end

    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && o_res_valid && o_res.status != ST_OK) |=> (r_phase == PH_ERROR))
        else $error("error result did not enter error phase");

    a_len16_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_LEN16) |-> (r_hbc <= 3'd1))
        else $error("16-bit length byte count out of range");

    a_key_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_MASK) |-> (r_hbc <= KEY_LAST))
        else $error("mask key byte count out of range");

    a_data_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_len != '0))
        else $error("payload phase with zero length");

endmodule

@@ test/tb_websocket_frame_deframer.sv @@
// Testbench for the WebSocket frame deframer: byte stream in, checked payload and status out.
module tb_websocket_frame_deframer;
    import wsd_pkg::*;

    localparam logic       CMD_BYTE     = 1'b0;
    localparam logic       CMD_CLEAR    = 1'b1;
    localparam logic [6:0] LEN7_EXT64   = 7'd127;
    localparam int         RANDOM_ITEMS = 750;
    localparam int         QUIET_LIMIT  = 400;

    typedef enum logic [1:0] {
        FORM_SHORT,
        FORM_EXT16,
        FORM_EXT64
    } t_len_form;

    logic             i_clk;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    logic             o_in_stall;
    logic             i_command   = 1'b0;
    logic [7:0]       i_in_byte   = 8'h00;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    logic [7:0]       o_payload_byte;
    logic             o_byte_valid;
    logic             o_frame_end;
    logic             o_fin_flag;
    logic             o_rsv1_flag;
    logic [3:0]       o_frame_opcode;
    logic [LEN_W-1:0] o_frame_length;
    logic [2:0]       o_status;

    t_phase      parse_phase;
    logic        hdr_fin;
    logic        hdr_rsv1;
    logic [3:0]  hdr_opcode;
    logic        hdr_masked;
    logic [63:0] frame_len;
    logic [62:0] payload_count;
    logic [31:0] key_word;
    logic [2:0]  ext_count;

    t_result deframed_out_q[$];
    int      accepted_items = 0;
    int      mismatches     = 0;
    int      quiet_cycles   = 0;
    int      rx_hold        = 0;
    bit      rx_burst       = 1'b0;
    bit      tx_burst       = 1'b0;

    websocket_frame_deframer dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void reset_parser();
        parse_phase   = PH_HDR1;
        hdr_fin       = 1'b0;
        hdr_rsv1      = 1'b0;
        hdr_opcode    = 4'h0;
        hdr_masked    = 1'b0;
        frame_len     = 64'd0;
        payload_count = 63'd0;
        key_word      = 32'd0;
        ext_count     = 3'd0;
    endfunction

    function automatic void push_result(logic [7:0] data, logic valid, logic end_mark,
                                        t_status code);
        t_result r;
        r.payload_byte = data;
        r.byte_valid   = valid;
        r.frame_end    = end_mark;
        r.fin_flag     = hdr_fin;
        r.rsv1_flag    = hdr_rsv1;
        r.frame_opcode = hdr_opcode;
        r.frame_length = frame_len[LEN_W-1:0];
        r.status       = code;
        deframed_out_q.insert(deframed_out_q.size(), r);
    endfunction

    function automatic void flag_error(t_status code);
        parse_phase = PH_ERROR;
        push_result(8'h00, 1'b0, 1'b0, code);
    endfunction

    function automatic void header_done();
        payload_count = 63'd0;
        ext_count     = 3'd0;
        if (hdr_masked) begin
            parse_phase = PH_MASK;
        end else if (frame_len == 64'd0) begin
            parse_phase = PH_HDR1;
            push_result(8'h00, 1'b0, 1'b1, ST_OK);
        end else begin
            parse_phase = PH_DATA;
        end
    endfunction

    function automatic void deframe_byte(logic cmd, logic [7:0] b);
        int         sh;
        logic [7:0] data;
        logic       end_mark;
        if (cmd == CMD_CLEAR) begin
            reset_parser();
            return;
        end
        case (parse_phase)
            PH_HDR1: begin
                hdr_fin    = b[7];
                hdr_rsv1   = b[6];
                hdr_opcode = b[3:0];
                if ((b[5:4] & HDR1_RSV_MASK) != 2'b00) flag_error(ST_RSV);
                else parse_phase = PH_HDR2;
            end
            PH_HDR2: begin
                hdr_masked = b[7];
                ext_count  = 3'd0;
                if (b[6:0] <= LEN7_MAX) begin
                    frame_len = {57'd0, b[6:0]};
                    header_done();
                end else begin
                    frame_len   = 64'd0;
                    parse_phase = (b[6:0] == LEN7_EXT16) ? PH_LEN16 : PH_LEN64;
                end
            end
            PH_LEN16: begin
                frame_len = {48'd0, frame_len[7:0], b};
                if (ext_count == 3'd0) ext_count = 3'd1;
                else if (frame_len <= 64'd125) flag_error(ST_LEN16_SHORT);
                else header_done();
            end
            PH_LEN64: begin
                frame_len = {frame_len[55:0], b};
                if (ext_count < LEN64_LAST) ext_count++;
                else if (frame_len[63]) flag_error(ST_LEN64_TOP);
                else if (frame_len <= 64'd65535) flag_error(ST_LEN64_SHORT);
                else header_done();
            end
            PH_MASK: begin
                key_word = {key_word[23:0], b};
                if (ext_count < KEY_LAST) begin
                    ext_count++;
                end else begin
                    ext_count     = 3'd0;
                    payload_count = 63'd0;
                    if (frame_len == 64'd0) begin
                        parse_phase = PH_HDR1;
                        push_result(8'h00, 1'b0, 1'b1, ST_OK);
                    end else begin
                        parse_phase = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                data = b;
                if (hdr_masked) begin
                    sh   = 24 - 8 * int'(payload_count[1:0]);
                    data = data ^ key_word[sh +: 8];
                end
                payload_count = payload_count + 63'd1;
                end_mark      = ({1'b0, payload_count} >= frame_len);
                push_result(data, 1'b1, end_mark, ST_OK);
                if (end_mark) begin
                    parse_phase   = PH_HDR1;
                    payload_count = 63'd0;
                    ext_count     = 3'd0;
                end
            end
            default: begin
            end
        endcase
    endfunction

    task automatic send_item(input logic cmd, input logic [7:0] value);
        int gap;
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_in_byte  <= value;
        do @(posedge i_clk); while (o_in_stall);
        if (cmd == CMD_CLEAR || parse_phase != PH_ERROR) accepted_items++;
        deframe_byte(cmd, value);
        gap = tx_burst ? 0 : $urandom_range(19);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_frame(input logic [7:0] hdr1, input logic masked, input t_len_form form,
                              input logic [63:0] len, input int n_payload);
        logic [6:0] len7;
        case (form)
            FORM_SHORT: len7 = len[6:0];
            FORM_EXT16: len7 = LEN7_EXT16;
            default:    len7 = LEN7_EXT64;
        endcase
        send_item(CMD_BYTE, hdr1);
        send_item(CMD_BYTE, {masked, len7});
        if (form == FORM_EXT16) begin
            send_item(CMD_BYTE, len[15:8]);
            send_item(CMD_BYTE, len[7:0]);
        end else if (form == FORM_EXT64) begin
            for (int i = 7; i >= 0; i--) send_item(CMD_BYTE, len[8*i +: 8]);
        end
        if (masked) repeat (4) send_item(CMD_BYTE, 8'($urandom_range(255)));
        repeat (n_payload) send_item(CMD_BYTE, 8'($urandom_range(255)));
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (deframed_out_q.size() != 0);
    endtask

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            rx_hold = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (deframed_out_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: expected no transaction, got payload_byte %0h status %0d",
                             $time, o_payload_byte, o_status);
                end else begin
                    want = deframed_out_q.pop_front();
                    check_field("payload_byte", 64'(want.payload_byte), 64'(o_payload_byte));
                    check_field("byte_valid", 64'(want.byte_valid), 64'(o_byte_valid));
                    check_field("frame_end", 64'(want.frame_end), 64'(o_frame_end));
                    check_field("fin_flag", 64'(want.fin_flag), 64'(o_fin_flag));
                    check_field("rsv1_flag", 64'(want.rsv1_flag), 64'(o_rsv1_flag));
                    check_field("frame_opcode", 64'(want.frame_opcode), 64'(o_frame_opcode));
                    check_field("frame_length", 64'(want.frame_length), 64'(o_frame_length));
                    check_field("status", 64'(want.status), 64'(o_status));
                end
                rx_hold = rx_burst ? 0 : $urandom_range(19);
                if ($urandom_range(31) == 0) rx_burst = !rx_burst;
            end
            if (rx_hold > 0) begin
                i_out_stall <= 1'b1;
                rx_hold--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("simulation failed");
        $finish;
    end

    task automatic test_reset();
        reset_parser();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    endtask

    task automatic test_zero_length();
        send_frame(8'h89, 1'b0, FORM_SHORT, 64'd0, 0);
        send_frame(8'h0A, 1'b1, FORM_SHORT, 64'd0, 0);
        wait_drain();
    endtask

    task automatic test_header_errors();
        send_frame(8'hFF, 1'b0, FORM_SHORT, 64'd0, 0);
        send_item(CMD_CLEAR, 8'hFF);
        send_frame(8'h02, 1'b1, FORM_EXT16, 64'd125, 0);
        send_item(CMD_CLEAR, 8'h00);
        send_frame(8'h80, 1'b0, FORM_EXT64, 64'hFFFF_FFFF_FFFF_FFFF, 0);
        send_item(CMD_CLEAR, 8'h5A);
        wait_drain();
    endtask

    task automatic test_random_stream();
        int          pick;
        int          n;
        logic [63:0] len;
        logic [7:0]  hdr1;
        t_len_form   form;
        while (accepted_items < RANDOM_ITEMS) begin
            tx_burst = ($urandom_range(3) == 0);
            hdr1 = 8'($urandom_range(255));
            hdr1[5:4] = 2'b00;
            pick = $urandom_range(99);
            if (pick < 70) begin
                case ($urandom_range(9))
                    0, 1, 2, 3, 4, 5: begin
                        form = FORM_SHORT;
                        len  = 64'($urandom_range(12));
                    end
                    6: begin
                        form = FORM_SHORT;
                        len  = 64'($urandom_range(125));
                    end
                    7: begin
                        form = FORM_EXT16;
                        len  = 64'($urandom_range(160, 126));
                    end
                    8: begin
                        form = FORM_EXT16;
                        len  = 64'($urandom_range(65535, 161));
                    end
                    default: begin
                        form = FORM_EXT64;
                        len  = {$urandom(), $urandom()};
                        len[63] = 1'b0;
                        if (len <= 64'd65535) len[16] = 1'b1;
                    end
                endcase
                n = (len > 64'd160) ? $urandom_range(20) : int'(len);
                if (n > 0 && $urandom_range(9) == 0) n = $urandom_range(n - 1);
                send_frame(hdr1, 1'($urandom_range(1)), form, len, n);
                if (64'(n) < len) send_item(CMD_CLEAR, 8'($urandom_range(255)));
            end else if (pick < 85) begin
                case ($urandom_range(3))
                    0: begin
                        hdr1[5:4] = 2'($urandom_range(3, 1));
                        form = FORM_SHORT;
                        len  = 64'($urandom_range(125));
                    end
                    1: begin
                        form = FORM_EXT16;
                        len  = 64'($urandom_range(125));
                    end
                    2: begin
                        form = FORM_EXT64;
                        len  = {$urandom(), $urandom()};
                        len[63] = 1'b1;
                    end
                    default: begin
                        form = FORM_EXT64;
                        len  = 64'($urandom_range(65535));
                    end
                endcase
                send_frame(hdr1, 1'($urandom_range(1)), form, len, $urandom_range(3));
                send_item(CMD_CLEAR, 8'($urandom_range(255)));
            end else if (pick < 98) begin
                repeat ($urandom_range(4, 1)) send_item(CMD_BYTE, 8'($urandom_range(255)));
                send_item(CMD_CLEAR, 8'($urandom_range(255)));
            end else begin
                wait_drain();
            end
        end
    endtask

    initial begin
        test_reset();
        test_zero_length();
        test_header_errors();
        test_random_stream();
        wait_drain();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

endmodule

@@ websocket_frame_deframer.f @@
design/wsd_pkg.sv
design/wsd_parse.sv
design/websocket_frame_deframer.sv
test/tb_websocket_frame_deframer.sv
